>>> rtl/see_pkg.sv
package see_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIVZERO  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_POPX,
    S_POPY,
    S_LATY,
    S_EXEC,
    S_ITER,
    S_PUSH,
    S_PEEK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic push_digit;
    logic set_pend;
    logic pop;
    logic peek;
    logic latch_x;
    logic latch_y;
    logic start_arith;
    logic push_result;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic last;
    logic pend_none;
    logic pend_iter;
    logic arith_done;
  } sts_t;

  function automatic op_t char_to_op(input logic [7:0] ch);
    op_t op;
    unique case (ch)
      CHAR_PLUS:  op = OP_ADD;
      CHAR_MINUS: op = OP_SUB;
      CHAR_STAR:  op = OP_MUL;
      CHAR_SLASH: op = OP_DIV;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

>>> rtl/see_ram.sv
module see_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/see_muldiv.sv
module see_muldiv import see_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   is_div,
  input  logic [VALUE_WIDTH-1:0] opa,
  input  logic [VALUE_WIDTH-1:0] opb,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] product,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int W  = VALUE_WIDTH;
  localparam int NW = $clog2(W);

  logic          busy_r;
  logic [NW-1:0] cnt_r;
  logic          div_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  mcand_r;

  logic [W-1:0]  opa_mag;
  logic [W-1:0]  opb_mag;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  assign opa_mag = opa[W-1] ? (~opa + W'(1)) : opa;
  assign opb_mag = opb[W-1] ? (~opb + W'(1)) : opb;

  // one restoring division step: shift in next dividend bit, trial subtract
  assign rem_sh = {acc_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, mcand_r};
  assign ge     = ~diff[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + NW'(1);
      if (cnt_r == NW'(W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r   <= is_div;
      acc_r   <= '0;
      quo_r   <= is_div ? opa_mag : opb;
      mcand_r <= is_div ? opb_mag : opa;
    end else if (busy_r) begin
      if (div_r) begin
        acc_r <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
      end else begin
        acc_r   <= acc_r + (quo_r[0] ? mcand_r : '0);
        quo_r   <= quo_r >> 1;
        mcand_r <= mcand_r << 1;
      end
    end
  end

  assign done     = busy_r && (cnt_r == NW'(W - 1));
  assign product  = acc_r;
  assign quotient = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiply/divide started while busy");

endmodule

>>> rtl/see_dp.sv
module see_dp import see_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_expression,
  output logic [31:0] out_result_value,
  output logic [8:0]  out_stack_depth,
  output logic [1:0]  out_status
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    char_r;
  logic          last_r;
  logic [CW-1:0] count_r;
  op_t           pend_r;
  logic          ovf_r;
  logic          dz_r;
  logic          rd_empty_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [31:0]   result_r;
  logic [8:0]    depth_r;
  logic [1:0]    status_r;

  op_t           op_in;
  logic          full;
  logic          empty;
  logic [W-1:0]  digit_val;
  logic [W-1:0]  pop_val;
  logic [W-1:0]  rd_data;
  logic [W-1:0]  z;
  logic [W-1:0]  prod;
  logic [W-1:0]  quo;
  logic [W-1:0]  quo_fix;
  logic          x_zero;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] top_addr;
  logic          arith_done;

  assign op_in     = char_to_op(char_r);
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign empty     = (count_r == '0);
  assign digit_val = W'(char_r - CHAR_ZERO);
  assign top_addr  = AW'(count_r - CW'(1));
  // an empty stack pops as all ones
  assign pop_val   = rd_empty_r ? '1 : rd_data;
  assign x_zero    = (x_r == '0);
  assign quo_fix   = (y_r[W-1] ^ x_r[W-1]) ? (~quo + W'(1)) : quo;

  always_comb begin
    case (pend_r)
      OP_ADD:  z = y_r + x_r;
      OP_SUB:  z = y_r - x_r;
      OP_MUL:  z = prod;
      OP_DIV:  z = x_zero ? '0 : quo_fix;
      default: z = '0;
    endcase
  end

  assign ram_we = (cmd.push_digit || cmd.push_result) && !full;
  assign ram_re = (cmd.pop || cmd.peek) && !empty;

  see_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count_r)),
    .wdata (cmd.push_digit ? digit_val : z),
    .re    (ram_re),
    .raddr (top_addr),
    .rdata (rd_data)
  );

  see_muldiv #(
    .VALUE_WIDTH (W)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_arith),
    .is_div   (pend_r == OP_DIV),
    .opa      (y_r),
    .opb      (x_r),
    .done     (arith_done),
    .product  (prod),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= OP_NONE;
      ovf_r   <= 1'b0;
      dz_r    <= 1'b0;
    end else if (cmd.emit) begin
      count_r <= '0;
      pend_r  <= OP_NONE;
      ovf_r   <= 1'b0;
      dz_r    <= 1'b0;
    end else begin
      if (cmd.push_digit || cmd.push_result) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.pop && !empty) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.set_pend) begin
        pend_r <= op_in;
      end
      if (cmd.push_result && pend_r == OP_DIV && x_zero) begin
        dz_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      char_r <= in_char_code;
      last_r <= in_end_of_expression;
    end
    if (cmd.pop || cmd.peek) begin
      rd_empty_r <= empty;
    end
    if (cmd.latch_x) begin
      x_r <= pop_val;
    end
    if (cmd.latch_y) begin
      y_r <= pop_val;
    end
    if (cmd.emit) begin
      result_r <= 32'(signed'(pop_val));
      depth_r  <= 9'(count_r);
      status_r <= ovf_r ? STATUS_OVERFLOW : (dz_r ? STATUS_DIVZERO : STATUS_OK);
    end
  end

  assign sts.is_digit   = (char_r >= CHAR_ZERO) && (char_r <= CHAR_NINE);
  assign sts.is_op      = (op_in != OP_NONE);
  assign sts.last       = last_r;
  assign sts.pend_none  = (pend_r == OP_NONE);
  assign sts.pend_iter  = (pend_r == OP_MUL) || (pend_r == OP_DIV);
  assign sts.arith_done = arith_done;

  assign out_result_value = result_r;
  assign out_stack_depth  = depth_r;
  assign out_status       = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0) && (pend_r == OP_NONE) && !ovf_r && !dz_r)
    else $error("state not cleared after result");

endmodule

>>> rtl/see_ctrl.sv
module see_ctrl import see_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
          final_nxt = 1'b0;
        end
      end
      S_DECODE: begin
        if (sts.is_op && !sts.pend_none) begin
          state_nxt = S_POPX;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.pend_none) begin
          state_nxt = S_PEEK;
        end else begin
          state_nxt = S_POPX;
          final_nxt = 1'b1;
        end
      end
      S_POPX: state_nxt = S_POPY;
      S_POPY: state_nxt = S_LATY;
      S_LATY: state_nxt = S_EXEC;
      S_EXEC: state_nxt = sts.pend_iter ? S_ITER : S_PUSH;
      S_ITER: begin
        if (sts.arith_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: state_nxt = final_r ? S_PEEK : S_CHECK;
      S_PEEK: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        cmd.push_digit = sts.is_digit;
        cmd.set_pend   = sts.is_op && sts.pend_none;
      end
      S_POPX: cmd.pop = 1'b1;
      S_POPY: begin
        cmd.latch_x = 1'b1;
        cmd.pop     = 1'b1;
      end
      S_LATY: cmd.latch_y = 1'b1;
      S_EXEC: cmd.start_arith = sts.pend_iter;
      S_PUSH: begin
        cmd.push_result = 1'b1;
        cmd.set_pend    = !final_r;
      end
      S_PEEK: cmd.peek = 1'b1;
      S_EMIT: cmd.emit = slot_free;
      default: cmd = '0;
    endcase
  end

  assign out_valid = out_valid_r;

  a_done_in_iter: assert property (@(posedge clk) disable iff (!rst_n)
    sts.arith_done |-> state_r == S_ITER)
    else $error("arithmetic done outside iteration");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accepted transaction not decoded");

endmodule

>>> rtl/stack_expression_evaluator.sv
// Steps: a digit is loaded, decoded and pushed; an operator with none pending becomes
//   pending, else it first reduces the pending operator (pop x, pop y, execute, push).
// Last character adds its reduce, then a peek and the load of the result register;
//   out_valid rises with that load, later while the previous result still waits.
// Throughput: one transaction at a time, set by the shift-add / restoring
//   divide unit that takes one bit per cycle, and a registered-read stack RAM.
// Reset (rst_n, synchronous, active low): stack empty, no operator pending, flags clear.
module stack_expression_evaluator import see_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_expression,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_value,
  output logic [8:0]  out_stack_depth,
  output logic [1:0]  out_status
);

  cmd_t cmd;
  sts_t sts;

  see_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  see_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_char_code         (in_char_code),
    .in_end_of_expression (in_end_of_expression),
    .out_result_value     (out_result_value),
    .out_stack_depth      (out_stack_depth),
    .out_status           (out_status)
  );

endmodule
